@@ design/ascii_command_frame_decoder_assert.svh @@
// Assertion macros shared by the frame decoder RTL.
`ifndef ASCII_COMMAND_FRAME_DECODER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/acfd_pkg.sv @@
// Types and constants of the ASCII command frame decoder.
`timescale 1ns / 1ps

package acfd_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SYMBOL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_SYMBOL   = 1'd1;

    // Reset values
    localparam logic [7:0]  START_SYMBOL_RST = 8'd35;
    localparam logic [7:0]  END_SYMBOL_RST   = 8'd59;
    localparam logic [15:0] RATE_RST         = 16'd2500;
    localparam logic [7:0]  DIVIDER_RST      = 8'd1;

    // Number of leading frame bytes that the decoder looks at
    localparam int DECODE_BYTES = 7;

    // ASCII characters
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ADC_STOP,
        CMD_ADC_START,
        CMD_SET_RATE,
        CMD_TEST1,
        CMD_TEST2,
        CMD_TEST3,
        CMD_SINE,
        CMD_RAMP,
        CMD_HIGH,
        CMD_SQUARE,
        CMD_ECG,
        CMD_PWM_OFF
    } cmd_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } rx_state_t;

    typedef logic [DECODE_BYTES-1:0][7:0] decode_bytes_t;

    // Outcome of decoding one frame
    typedef struct packed {
        cmd_code_t   cmd_code;
        logic        rate_load;
        logic [15:0] rate_value;
        logic        div_load;
        logic [7:0]  div_value;
    } decode_t;

    // One result transaction
    typedef struct packed {
        logic [3:0]  cmd_code;
        logic [15:0] sample_rate;
        logic [7:0]  pwm_divider;
    } result_t;

endpackage

@@ design/acfd_if.sv @@
// Channel interfaces of the ASCII command frame decoder.
`timescale 1ns / 1ps

interface acfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acfd_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd_code;
    logic [15:0] sample_rate;
    logic [7:0]  pwm_divider;

    modport source (output valid, output cmd_code, output sample_rate,
                    output pwm_divider, input ready);
    modport sink   (input valid, input cmd_code, input sample_rate,
                    input pwm_divider, output ready);
endinterface

interface acfd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [acfd_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [7:0]                       wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ design/acfd_decode.sv @@
// Fixed-position decoder for one stored command frame.
`timescale 1ns / 1ps

module acfd_decode
(
    input  acfd_pkg::decode_bytes_t frame,
    output acfd_pkg::decode_t       dec
);

    logic [15:0] rd2, rd3, rd4, rd5;
    logic [15:0] rate2, rate3, rate4;
    logic [7:0]  pd5, pd6;

    // Digits are the byte minus ASCII zero, wrapping to the field width
    always_comb
    begin
        rd2 = {8'd0, frame[2]} - {8'd0, acfd_pkg::CH_0};
        rd3 = {8'd0, frame[3]} - {8'd0, acfd_pkg::CH_0};
        rd4 = {8'd0, frame[4]} - {8'd0, acfd_pkg::CH_0};
        rd5 = {8'd0, frame[5]} - {8'd0, acfd_pkg::CH_0};
        rate2 = 16'(rd2 * 16'd10) + rd3;
        rate3 = 16'(rd2 * 16'd100) + 16'(rd3 * 16'd10) + rd4;
        rate4 = 16'(rd2 * 16'd1000) + 16'(rd3 * 16'd100) + 16'(rd4 * 16'd10) + rd5;
        pd5 = frame[5] - acfd_pkg::CH_0;
        pd6 = frame[6] - acfd_pkg::CH_0;
    end

    always_comb
    begin
        dec.cmd_code   = acfd_pkg::CMD_NONE;
        dec.rate_load  = 1'b0;
        dec.rate_value = rate4;
        dec.div_load   = 1'b0;
        dec.div_value  = 8'(pd5 * 8'd10) + pd6;

        if (frame[4] == acfd_pkg::CH_DOT)
        begin
            dec.rate_value = rate2;
        end
        else if (frame[5] == acfd_pkg::CH_DOT)
        begin
            dec.rate_value = rate3;
        end

        if (frame[6] == acfd_pkg::CH_DOT)
        begin
            dec.div_value = pd5;
        end

        case (frame[0])
            acfd_pkg::CH_M:
            begin
                if (frame[1] == acfd_pkg::CH_0)
                begin
                    dec.cmd_code = acfd_pkg::CMD_ADC_STOP;
                end
                else if (frame[1] == acfd_pkg::CH_1)
                begin
                    dec.cmd_code = acfd_pkg::CMD_ADC_START;
                end
            end
            acfd_pkg::CH_C:
            begin
                if (frame[1] == acfd_pkg::CH_COMMA)
                begin
                    dec.cmd_code  = acfd_pkg::CMD_SET_RATE;
                    dec.rate_load = 1'b1;
                end
            end
            acfd_pkg::CH_T:
            begin
                case (frame[1])
                    acfd_pkg::CH_1: dec.cmd_code = acfd_pkg::CMD_TEST1;
                    acfd_pkg::CH_2: dec.cmd_code = acfd_pkg::CMD_TEST2;
                    acfd_pkg::CH_3: dec.cmd_code = acfd_pkg::CMD_TEST3;
                    default:        dec.cmd_code = acfd_pkg::CMD_NONE;
                endcase
            end
            acfd_pkg::CH_P:
            begin
                if (frame[1] == acfd_pkg::CH_1 && frame[2] == acfd_pkg::CH_COMMA
                    && frame[4] == acfd_pkg::CH_COMMA)
                begin
                    dec.div_load = 1'b1;
                    case (frame[3])
                        acfd_pkg::CH_S: dec.cmd_code = acfd_pkg::CMD_SINE;
                        acfd_pkg::CH_R: dec.cmd_code = acfd_pkg::CMD_RAMP;
                        acfd_pkg::CH_H: dec.cmd_code = acfd_pkg::CMD_HIGH;
                        acfd_pkg::CH_Q: dec.cmd_code = acfd_pkg::CMD_SQUARE;
                        acfd_pkg::CH_E: dec.cmd_code = acfd_pkg::CMD_ECG;
                        default:        dec.cmd_code = acfd_pkg::CMD_NONE;
                    endcase
                end
                else if (frame[1] == acfd_pkg::CH_0)
                begin
                    dec.cmd_code = acfd_pkg::CMD_PWM_OFF;
                end
            end
            default:
            begin
                dec.cmd_code = acfd_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

@@ design/ascii_command_frame_decoder.sv @@
// Top level of the ASCII command frame decoder.
//
//  Channel | Direction | Payload                              | Transaction
//  --------+-----------+--------------------------------------+-------------------------
//  rx      | in        | rx_byte[7:0]                         | one received byte
//  res     | out       | cmd_code[3:0] sample_rate[15:0]      | one decoded frame
//          |           | pwm_divider[7:0]                     |
//  cfg     | in        | reg_index (0 start, 1 end) wr_data   | one register write
//
// A byte is taken in the cycle it is offered while rx.ready is high: the frame state
// updates at the accepting edge, and an end symbol in a frame decodes the store into the
// output register, or the skid register behind a stalled head; one byte per cycle while ready.
// An output register and a skid register sit on the result side; rx.ready drops only
// while both hold results, and the configuration channel is always ready.
// Reset restores the default symbols, a zero store, a rate of 2500 and a divider of 1.
`timescale 1ns / 1ps

`include "ascii_command_frame_decoder_assert.svh"

module ascii_command_frame_decoder
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    acfd_byte_if.sink            rx,
    acfd_result_if.source        res,
    acfd_cfg_if.sink             cfg
);

    // The fill counter must reach FRAME_BYTES itself, which marks a full store.
    localparam int IDX_W = $clog2(FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(FRAME_BYTES);

    // Configuration registers
    logic [7:0] start_symbol_reg;
    logic [7:0] end_symbol_reg;

    // Frame reception state
    acfd_pkg::rx_state_t state_reg, state_next;
    logic [IDX_W-1:0]    fill_idx_reg, fill_idx_next;
    logic [7:0]          frame_reg  [FRAME_BYTES];
    logic [7:0]          frame_next [FRAME_BYTES];

    // Persistent settings carried in every result
    logic [15:0] rate_reg, rate_next;
    logic [7:0]  div_reg, div_next;

    // Output register and skid register
    logic              head_valid_reg, head_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    acfd_pkg::result_t head_reg, head_next;
    acfd_pkg::result_t skid_reg, skid_next;

    logic                    rx_take;
    logic                    res_take;
    logic                    is_start;
    logic                    is_end;
    logic                    push;
    acfd_pkg::decode_bytes_t dec_bytes;
    acfd_pkg::decode_t       dec;
    acfd_pkg::result_t       new_result;

    assign rx.ready  = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign rx_take   = rx.valid && rx.ready;
    assign res_take  = res.valid && res.ready;
    assign is_start  = (rx.rx_byte == start_symbol_reg);
    assign is_end    = (rx.rx_byte == end_symbol_reg);

    // A result is produced only when the end symbol arrives inside a frame.
    assign push = rx_take && (state_reg == acfd_pkg::ST_FRAME) && is_end;

    // The decoder only ever looks at the leading bytes of the store.
    always_comb
    begin
        for (int i = 0; i < acfd_pkg::DECODE_BYTES; i++)
        begin
            dec_bytes[i] = frame_reg[i];
        end
    end

    acfd_decode u_decode
    (
        .frame (dec_bytes),
        .dec   (dec)
    );

    // Result of this frame: code plus the settings as they stand after it.
    always_comb
    begin
        rate_next = dec.rate_load ? dec.rate_value : rate_reg;
        div_next  = dec.div_load  ? dec.div_value  : div_reg;
        if (!push)
        begin
            rate_next = rate_reg;
            div_next  = div_reg;
        end
        new_result.cmd_code    = dec.cmd_code;
        new_result.sample_rate = dec.rate_load ? dec.rate_value : rate_reg;
        new_result.pwm_divider = dec.div_load  ? dec.div_value  : div_reg;
    end

    // Next state of the frame receiver.
    always_comb
    begin
        state_next = state_reg;
        if (rx_take)
        begin
            case (state_reg)
                acfd_pkg::ST_IDLE:
                begin
                    if (is_start)
                    begin
                        state_next = acfd_pkg::ST_FRAME;
                    end
                end
                acfd_pkg::ST_FRAME:
                begin
                    // The end symbol closes the frame; any other byte arriving
                    // with the store already full aborts it.
                    if (is_end || fill_idx_reg == FULL_COUNT)
                    begin
                        state_next = acfd_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = acfd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Fill counter and frame store. The store is never cleared between
    // frames, so short frames are decoded against whatever bytes remain.
    always_comb
    begin
        fill_idx_next = fill_idx_reg;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_next[i] = frame_reg[i];
        end
        if (rx_take)
        begin
            if (state_reg == acfd_pkg::ST_IDLE)
            begin
                if (is_start)
                begin
                    fill_idx_next = '0;
                end
            end
            else if (!is_end && fill_idx_reg != FULL_COUNT)
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    if (fill_idx_reg == IDX_W'(i))
                    begin
                        frame_next[i] = rx.rx_byte;
                    end
                end
                fill_idx_next = fill_idx_reg + IDX_W'(1);
            end
        end
    end

    // Two-entry result buffer: the head drives the port, the skid catches a
    // result produced while the head is stalled.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (res_take)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = new_result;
            end
            else
            begin
                head_valid_next = push;
                head_next       = new_result;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_next = push;
            head_next       = new_result;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = new_result;
        end
    end

    assign res.valid       = head_valid_reg;
    assign res.cmd_code    = head_reg.cmd_code;
    assign res.sample_rate = head_reg.sample_rate;
    assign res.pwm_divider = head_reg.pwm_divider;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_symbol_reg <= acfd_pkg::START_SYMBOL_RST;
            end_symbol_reg   <= acfd_pkg::END_SYMBOL_RST;
            state_reg        <= acfd_pkg::ST_IDLE;
            fill_idx_reg     <= '0;
            rate_reg         <= acfd_pkg::RATE_RST;
            div_reg          <= acfd_pkg::DIVIDER_RST;
            head_valid_reg   <= 1'b0;
            skid_valid_reg   <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    acfd_pkg::CFG_START_SYMBOL: start_symbol_reg <= cfg.wr_data;
                    acfd_pkg::CFG_END_SYMBOL:   end_symbol_reg   <= cfg.wr_data;
                    default:                    start_symbol_reg <= start_symbol_reg;
                endcase
            end
            state_reg      <= state_next;
            fill_idx_reg   <= fill_idx_next;
            rate_reg       <= rate_next;
            div_reg        <= div_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_reg[i] <= frame_next[i];
            end
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // The skid register is only ever filled behind a valid head.
    `ACFD_ASSERT_IMPLY(a_skid_behind_head, clk, rst_n, skid_valid_reg, head_valid_reg, "skid valid without head")
    // The fill counter never runs past a full store.
    `ACFD_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_idx_reg <= FULL_COUNT, "fill index beyond store")
    // Closing a frame always returns the receiver to idle and leaves a result.
    `ACFD_ASSERT_NEXT(a_close_frame, clk, rst_n, push, state_reg == acfd_pkg::ST_IDLE && head_valid_reg, "frame not closed")
    // Outside a frame nothing is stored.
    `ACFD_ASSERT_NEXT(a_idle_no_fill, clk, rst_n, state_reg == acfd_pkg::ST_IDLE && !(rx_take && is_start), fill_idx_reg == $past(fill_idx_reg), "fill moved while idle")

endmodule
